@@ sv/utrb_pkg.sv @@
// ----------------------------------------------------------------------------
// utrb_pkg
// Shared types and constants for the transmit ring buffer with line-feed
// expansion.
// ----------------------------------------------------------------------------
package utrb_pkg;

    localparam int QUEUE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;

    localparam logic [ADDR_W-1:0] LAST_IDX    = ADDR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  DEPTH_CNT   = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0]  FULL_ONE    = CNT_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_TWO    = CNT_W'(QUEUE_DEPTH - 2);

    localparam logic [7:0] CODE_CR = 8'h0D;
    localparam logic [7:0] CODE_LF = 8'h0A;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_POLL  = 1'b1;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_ZERO     = 2'd2,
        ST_POLL     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WR_LF,
        S_RD,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        WSEL_CH,
        WSEL_CR,
        WSEL_LF
    } t_wsel;

    typedef struct packed {
        logic       func;
        logic [7:0] ch;
        logic       tx_ready;
    } t_in;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        t_status    status;
    } t_out;

    typedef struct packed {
        logic    take;
        t_status code;
        logic    push;
        t_wsel   wsel;
        logic    pop;
        logic    capture;
    } t_cmd;

    typedef struct packed {
        logic poll;
        logic tx_ready;
        logic zero_byte;
        logic line_feed;
        logic no_room;
        logic empty;
    } t_sts;

endpackage

@@ sv/utrb_ram.sv @@
// ----------------------------------------------------------------------------
// utrb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module utrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/utrb_dp.sv @@
// ----------------------------------------------------------------------------
// utrb_dp
// Datapath: queue memory, write and read indexes, fill level and result
// register.
// ----------------------------------------------------------------------------
module utrb_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  utrb_pkg::t_in  i_in,
    input  utrb_pkg::t_cmd i_cmd,
    output utrb_pkg::t_sts o_sts,
    output utrb_pkg::t_out o_out
);
    import utrb_pkg::*;

    logic [ADDR_W-1:0] r_wr_idx;
    logic [ADDR_W-1:0] n_wr_idx;
    logic [ADDR_W-1:0] r_rd_idx;
    logic [ADDR_W-1:0] n_rd_idx;
    logic [CNT_W-1:0]  count;
    logic [7:0]        wr_data;
    logic [7:0]        rd_data;
    t_out              r_res;

    // fill level without a modulo
    always_comb begin
        if (r_wr_idx >= r_rd_idx) begin
            count = CNT_W'(r_wr_idx) - CNT_W'(r_rd_idx);
        end else begin
            count = CNT_W'(r_wr_idx) + DEPTH_CNT - CNT_W'(r_rd_idx);
        end
    end

    always_comb begin
        o_sts.poll      = (i_in.func == FUNC_POLL);
        o_sts.tx_ready  = i_in.tx_ready;
        o_sts.zero_byte = (i_in.ch == 8'h00);
        o_sts.line_feed = (i_in.ch == CODE_LF);
        o_sts.no_room   = (i_in.ch == CODE_LF) ? (count >= FULL_TWO) : (count >= FULL_ONE);
        o_sts.empty     = (r_wr_idx == r_rd_idx);
    end

    always_comb begin
        case (i_cmd.wsel)
            WSEL_CR: wr_data = CODE_CR;
            WSEL_LF: wr_data = CODE_LF;
            default: wr_data = i_in.ch;
        endcase
    end

    always_comb begin
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        if (i_cmd.push) begin
            n_wr_idx = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + ADDR_W'(1);
        end
        if (i_cmd.pop) begin
            n_rd_idx = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
        end
    end

    utrb_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.push),
        .i_wr_addr (r_wr_idx),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.pop),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (rd_data)
    );

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_res.tx_valid <= 1'b0;
            r_res.tx_byte  <= 8'h00;
            r_res.status   <= i_cmd.code;
        end else if (i_cmd.capture) begin
            r_res.tx_valid <= 1'b1;
            r_res.tx_byte  <= rd_data;
        end
    end

    assign o_out = r_res;

endmodule

@@ sv/utrb_ctrl.sv @@
// ----------------------------------------------------------------------------
// utrb_ctrl
// Controller: sequences writes, line-feed expansion, queue reads and the
// result transfer.
// ----------------------------------------------------------------------------
module utrb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  utrb_pkg::t_sts i_sts,
    output utrb_pkg::t_cmd o_cmd
);
    import utrb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = (r_state != S_IDLE);
        o_out_valid = (r_state == S_OUT);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.poll) begin
                        o_cmd.code = ST_POLL;
                        if (i_sts.tx_ready && !i_sts.empty) begin
                            o_cmd.pop = 1'b1;
                            n_state   = S_RD;
                        end else begin
                            n_state = S_OUT;
                        end
                    end else if (i_sts.zero_byte) begin
                        o_cmd.code = ST_ZERO;
                        n_state    = S_OUT;
                    end else if (i_sts.no_room) begin
                        o_cmd.code = ST_FULL;
                        n_state    = S_OUT;
                    end else begin
                        o_cmd.code = ST_ACCEPTED;
                        o_cmd.push = 1'b1;
                        if (i_sts.line_feed) begin
                            o_cmd.wsel = WSEL_CR;
                            n_state    = S_WR_LF;
                        end else begin
                            o_cmd.wsel = WSEL_CH;
                            n_state    = S_OUT;
                        end
                    end
                end
            end
            S_WR_LF: begin
                o_cmd.push = 1'b1;
                o_cmd.wsel = WSEL_LF;
                n_state    = S_OUT;
            end
            S_RD: begin
                o_cmd.capture = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/uart_tx_ring_buffer_crlf.sv @@
// ----------------------------------------------------------------------------
// uart_tx_ring_buffer_crlf
// Transmit ring buffer for a serial port with line-feed to CR/LF expansion.
// ----------------------------------------------------------------------------
// One item is handled at a time and each gives exactly one result. A write
// item stores its byte in a 256-slot ring (one slot always stays empty); a
// line feed is stored as carriage return then line feed, a zero byte is
// dropped, and a write without room for the whole expansion is refused with
// a full status. A poll with the transmitter ready and bytes queued hands
// out the oldest byte. The result is offered in the cycle after the input
// transfer for most items, later for a line feed (second queue write) and
// for a poll that sends a byte (registered read of the queue memory).
// The next item is taken in the cycle after the result transfer, so no new
// item is taken while a result is pending. The queue memory needs no
// clearing after reset.
module uart_tx_ring_buffer_crlf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  utrb_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output utrb_pkg::t_out o_out
);
    import utrb_pkg::*;

    t_cmd cmd;
    t_sts sts;

    utrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    utrb_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_out   (o_out)
    );

    // no new item while a result is pending
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while result pending");

    // write results never carry a transmit byte
    a_write_no_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ST_POLL) |-> !o_out.tx_valid)
        else $error("write result flagged as transmit");

    // byte field is zero when nothing is sent
    a_idle_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.tx_valid) |-> (o_out.tx_byte == 8'h00))
        else $error("nonzero byte without transmit");

    // accepted item keeps the input side stalled next cycle
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after transfer");

endmodule
